### rtl/pre_pkg.sv
// Package for the page replacement engine: payload types, codes and helpers.
package pre_pkg;

  localparam int PAGE_ENTRIES_DEF = 64;
  localparam int POOL_SLOTS_DEF   = 64;

  localparam int PAGE_W  = 6;
  localparam int FRAME_W = 10;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 16;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 7;

  // request types
  localparam logic [1:0] REQ_ACCESS     = 2'd0;
  localparam logic [1:0] REQ_LOAD_POOL  = 2'd1;
  localparam logic [1:0] REQ_LOAD_ENTRY = 2'd2;

  // outcome codes
  localparam logic [2:0] OUT_HIT     = 3'd0;
  localparam logic [2:0] OUT_FILL    = 3'd1;
  localparam logic [2:0] OUT_REPLACE = 3'd2;
  localparam logic [2:0] OUT_NOFRAME = 3'd3;
  localparam logic [2:0] OUT_LOAD    = 3'd4;

  // replacement policies (any other code ranks by count)
  localparam logic [1:0] POLICY_FIFO = 2'd0;
  localparam logic [1:0] POLICY_LRU  = 2'd1;
  localparam logic [1:0] POLICY_LFU  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_POLICY = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_PAGES  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_FRAMES = 2'd2;

  localparam logic [1:0]        RESET_POLICY = POLICY_FIFO;
  localparam logic [CFG_DW-1:0] RESET_PAGES  = 7'd64;
  localparam logic [CFG_DW-1:0] RESET_FRAMES = 7'd64;

  localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [PAGE_W-1:0]  page;
    logic [TIME_W-1:0]  timestamp;
    logic               load_valid;
    logic [FRAME_W-1:0] load_frame;
    logic [TIME_W-1:0]  load_arrival;
    logic [TIME_W-1:0]  load_last_access;
    logic [COUNT_W-1:0] load_count;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame_out;
    logic [2:0]         outcome;
    logic [PAGE_W-1:0]  victim_page;
  } rsp_t;

  typedef struct packed {
    logic               valid;
    logic [FRAME_W-1:0] frame;
    logic [TIME_W-1:0]  arrival;
    logic [TIME_W-1:0]  last_access;
    logic [COUNT_W-1:0] count;
  } entry_t;

  typedef struct packed {
    logic               full;
    logic [FRAME_W-1:0] frame;
  } pool_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_POOL_SCAN,
    ST_VICT_SCAN,
    ST_VICT_CLEAR,
    ST_FILL_WRITE,
    ST_DONE
  } state_t;

  function automatic logic [COUNT_W-1:0] count_bump(input logic [COUNT_W-1:0] c);
    return (c == COUNT_MAX) ? c : c + 1'b1;
  endfunction

endpackage

### rtl/pre_ram.sv
// Generic single-write, single-read RAM with registered read data.
module pre_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/page_replacement_engine.sv
// Page table and free-frame pool with FIFO / LRU / LFU victim selection.
// From input beat to result beat: a load goes straight to the result, a hit reads
// the page table, a fill scans the pool to the first full slot, a replacement scans
// frames_in_use slots then pages_in_use entries (both capped at the store size), one
// RAM read and compare per cycle. One item at a time; the next beat is taken the
// cycle after the result is registered. Reset: a clearing pass zeroes both RAMs.
module page_replacement_engine #(
  parameter int PAGE_ENTRIES = pre_pkg::PAGE_ENTRIES_DEF,
  parameter int POOL_SLOTS   = pre_pkg::POOL_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pre_pkg::req_t                 in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pre_pkg::rsp_t                 out_data,
  input  logic                          cfg_we,
  input  logic [pre_pkg::CFG_AW-1:0]    cfg_addr,
  input  logic [pre_pkg::CFG_DW-1:0]    cfg_wdata
);

  localparam int PAGE_AW   = (PAGE_ENTRIES > 1) ? $clog2(PAGE_ENTRIES) : 1;
  localparam int POOL_AW   = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;
  localparam int MAX_DEPTH = (PAGE_ENTRIES > POOL_SLOTS) ? PAGE_ENTRIES : POOL_SLOTS;
  localparam int SCAN_W    = $clog2(MAX_DEPTH + 1);
  localparam int ENTRY_W   = $bits(pre_pkg::entry_t);
  localparam int POOL_W    = $bits(pre_pkg::pool_t);
  localparam logic [SCAN_W-1:0] CLR_LAST = SCAN_W'(MAX_DEPTH - 1);

  pre_pkg::state_t state, state_next;

  logic [1:0]                  policy;
  logic [pre_pkg::CFG_DW-1:0]  pages_in_use;
  logic [pre_pkg::CFG_DW-1:0]  frames_in_use;

  logic [SCAN_W-1:0]           clr_idx;
  logic [SCAN_W-1:0]           issue_idx;
  logic [SCAN_W-1:0]           chk_idx;
  logic                        chk_vld;
  logic                        have_best;
  logic [PAGE_AW-1:0]          best_idx;
  logic [pre_pkg::TIME_W-1:0]  best_rank;
  logic [pre_pkg::FRAME_W-1:0] best_frame;
  logic [pre_pkg::FRAME_W-1:0] fill_frame;
  logic [pre_pkg::PAGE_W-1:0]  pg_q;
  logic [pre_pkg::TIME_W-1:0]  ts_q;
  logic [pre_pkg::COUNT_W-1:0] pg_count;
  pre_pkg::rsp_t               res;

  logic                        ent_we;
  logic [PAGE_AW-1:0]          ent_waddr;
  pre_pkg::entry_t             ent_wdata;
  logic [PAGE_AW-1:0]          ent_raddr;
  pre_pkg::entry_t             ent_rdata;
  logic                        pool_we;
  logic [POOL_AW-1:0]          pool_waddr;
  pre_pkg::pool_t              pool_wdata;
  logic [POOL_AW-1:0]          pool_raddr;
  pre_pkg::pool_t              pool_rdata;

  logic                        in_fire;
  logic                        page_ok;
  logic                        slot_ok;
  logic                        is_load;
  logic [SCAN_W-1:0]           pn;
  logic [SCAN_W-1:0]           fn;
  logic                        pool_hit;
  logic                        pool_done;
  logic                        vict_done;
  logic [pre_pkg::TIME_W-1:0]  rank_cand;
  logic                        better;
  logic                        out_free;

  pre_ram #(.WIDTH(ENTRY_W), .DEPTH(PAGE_ENTRIES)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  pre_ram #(.WIDTH(POOL_W), .DEPTH(POOL_SLOTS)) u_pool_ram (
    .clk   (clk),
    .we    (pool_we),
    .waddr (pool_waddr),
    .wdata (pool_wdata),
    .raddr (pool_raddr),
    .rdata (pool_rdata)
  );

  assign in_fire  = in_valid & in_ready;
  assign page_ok  = 32'(in_data.page) < 32'(PAGE_ENTRIES);
  assign slot_ok  = 32'(in_data.page) < 32'(POOL_SLOTS);
  assign is_load  = (in_data.req_type == pre_pkg::REQ_LOAD_POOL) ||
                    (in_data.req_type == pre_pkg::REQ_LOAD_ENTRY);
  assign out_free = ~out_valid | out_ready;

  // search limits saturate at the store size
  always_comb begin
    if (32'(pages_in_use) > 32'(PAGE_ENTRIES)) begin
      pn = SCAN_W'(PAGE_ENTRIES);
    end else begin
      pn = SCAN_W'(pages_in_use);
    end
    if (32'(frames_in_use) > 32'(POOL_SLOTS)) begin
      fn = SCAN_W'(POOL_SLOTS);
    end else begin
      fn = SCAN_W'(frames_in_use);
    end
  end

  // shared rank compare for the victim scan
  always_comb begin
    unique case (policy)
      pre_pkg::POLICY_FIFO: rank_cand = ent_rdata.arrival;
      pre_pkg::POLICY_LRU:  rank_cand = ent_rdata.last_access;
      default:              rank_cand = pre_pkg::TIME_W'(ent_rdata.count);
    endcase
  end

  assign better    = chk_vld & ent_rdata.valid & (~have_best | (rank_cand < best_rank));
  assign pool_hit  = chk_vld & pool_rdata.full;
  assign pool_done = issue_idx >= fn;
  assign vict_done = (issue_idx >= pn) & ~chk_vld;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      pre_pkg::ST_CLEAR: begin
        if (clr_idx == CLR_LAST) state_next = pre_pkg::ST_IDLE;
      end
      pre_pkg::ST_IDLE: begin
        if (in_fire) begin
          if ((in_data.req_type == pre_pkg::REQ_ACCESS) && page_ok) begin
            state_next = pre_pkg::ST_LOOKUP;
          end else begin
            state_next = pre_pkg::ST_DONE;
          end
        end
      end
      pre_pkg::ST_LOOKUP: begin
        state_next = ent_rdata.valid ? pre_pkg::ST_DONE : pre_pkg::ST_POOL_SCAN;
      end
      pre_pkg::ST_POOL_SCAN: begin
        if (pool_hit) begin
          state_next = pre_pkg::ST_FILL_WRITE;
        end else if (pool_done) begin
          state_next = pre_pkg::ST_VICT_SCAN;
        end
      end
      pre_pkg::ST_VICT_SCAN: begin
        if (vict_done) begin
          state_next = have_best ? pre_pkg::ST_VICT_CLEAR : pre_pkg::ST_DONE;
        end
      end
      pre_pkg::ST_VICT_CLEAR: state_next = pre_pkg::ST_FILL_WRITE;
      pre_pkg::ST_FILL_WRITE: state_next = pre_pkg::ST_DONE;
      pre_pkg::ST_DONE: begin
        if (out_free) state_next = pre_pkg::ST_IDLE;
      end
    endcase
  end

  // ready and RAM ports
  always_comb begin
    in_ready   = 1'b0;
    ent_we     = 1'b0;
    ent_waddr  = PAGE_AW'(pg_q);
    ent_wdata  = '0;
    ent_raddr  = issue_idx[PAGE_AW-1:0];
    pool_we    = 1'b0;
    pool_waddr = chk_idx[POOL_AW-1:0];
    pool_wdata = '0;
    pool_raddr = issue_idx[POOL_AW-1:0];
    unique case (state)
      pre_pkg::ST_CLEAR: begin
        ent_we     = 32'(clr_idx) < 32'(PAGE_ENTRIES);
        ent_waddr  = clr_idx[PAGE_AW-1:0];
        pool_we    = 32'(clr_idx) < 32'(POOL_SLOTS);
        pool_waddr = clr_idx[POOL_AW-1:0];
      end
      pre_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        ent_raddr = PAGE_AW'(in_data.page);
        if (in_fire && (in_data.req_type == pre_pkg::REQ_LOAD_ENTRY) && page_ok) begin
          ent_we                = 1'b1;
          ent_waddr             = PAGE_AW'(in_data.page);
          ent_wdata.valid       = in_data.load_valid;
          ent_wdata.frame       = in_data.load_frame;
          ent_wdata.arrival     = in_data.load_arrival;
          ent_wdata.last_access = in_data.load_last_access;
          ent_wdata.count       = in_data.load_count;
        end
        if (in_fire && (in_data.req_type == pre_pkg::REQ_LOAD_POOL) && slot_ok) begin
          pool_we          = 1'b1;
          pool_waddr       = POOL_AW'(in_data.page);
          pool_wdata.full  = in_data.load_valid;
          pool_wdata.frame = in_data.load_frame;
        end
      end
      pre_pkg::ST_LOOKUP: begin
        if (ent_rdata.valid) begin
          ent_we                = 1'b1;
          ent_wdata             = ent_rdata;
          ent_wdata.last_access = ts_q;
          ent_wdata.count       = pre_pkg::count_bump(ent_rdata.count);
        end
      end
      pre_pkg::ST_POOL_SCAN: begin
        pool_we = pool_hit;
      end
      pre_pkg::ST_VICT_CLEAR: begin
        ent_we    = 1'b1;
        ent_waddr = best_idx;
      end
      pre_pkg::ST_FILL_WRITE: begin
        ent_we                = 1'b1;
        ent_wdata.valid       = 1'b1;
        ent_wdata.frame       = fill_frame;
        ent_wdata.arrival     = ts_q;
        ent_wdata.last_access = ts_q;
        ent_wdata.count       = pre_pkg::count_bump(pg_count);
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pre_pkg::ST_CLEAR;
      clr_idx       <= '0;
      chk_vld       <= 1'b0;
      have_best     <= 1'b0;
      out_valid     <= 1'b0;
      policy        <= pre_pkg::RESET_POLICY;
      pages_in_use  <= pre_pkg::RESET_PAGES;
      frames_in_use <= pre_pkg::RESET_FRAMES;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        unique case (cfg_addr)
          pre_pkg::CFG_POLICY: policy        <= cfg_wdata[1:0];
          pre_pkg::CFG_PAGES:  pages_in_use  <= cfg_wdata;
          pre_pkg::CFG_FRAMES: frames_in_use <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if (state == pre_pkg::ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
      unique case (state)
        pre_pkg::ST_LOOKUP: chk_vld <= 1'b0;
        pre_pkg::ST_POOL_SCAN: begin
          chk_vld   <= ~pool_done;
          have_best <= 1'b0;
        end
        pre_pkg::ST_VICT_SCAN: begin
          chk_vld <= issue_idx < pn;
          if (better) have_best <= 1'b1;
        end
        default: begin
        end
      endcase
      if ((state == pre_pkg::ST_DONE) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pg_q <= in_data.page;
      ts_q <= in_data.timestamp;
    end
    unique case (state)
      pre_pkg::ST_IDLE: begin
        if (in_fire) begin
          res.frame_out   <= '0;
          res.outcome     <= is_load ? pre_pkg::OUT_LOAD : pre_pkg::OUT_NOFRAME;
          res.victim_page <= '0;
        end
      end
      pre_pkg::ST_LOOKUP: begin
        issue_idx <= '0;
        pg_count  <= ent_rdata.count;
        if (ent_rdata.valid) begin
          res.frame_out <= ent_rdata.frame;
          res.outcome   <= pre_pkg::OUT_HIT;
        end
      end
      pre_pkg::ST_POOL_SCAN: begin
        chk_idx <= issue_idx;
        if (pool_done) begin
          issue_idx <= '0;
        end else begin
          issue_idx <= issue_idx + 1'b1;
        end
        if (pool_hit) begin
          fill_frame    <= pool_rdata.frame;
          res.frame_out <= pool_rdata.frame;
          res.outcome   <= pre_pkg::OUT_FILL;
        end
      end
      pre_pkg::ST_VICT_SCAN: begin
        chk_idx <= issue_idx;
        if (issue_idx < pn) issue_idx <= issue_idx + 1'b1;
        if (better) begin
          best_idx   <= chk_idx[PAGE_AW-1:0];
          best_rank  <= rank_cand;
          best_frame <= ent_rdata.frame;
        end
      end
      pre_pkg::ST_VICT_CLEAR: begin
        fill_frame      <= best_frame;
        res.frame_out   <= best_frame;
        res.outcome     <= pre_pkg::OUT_REPLACE;
        res.victim_page <= pre_pkg::PAGE_W'(best_idx);
      end
      pre_pkg::ST_DONE: begin
        if (out_free) out_data <= res;
      end
      default: begin
      end
    endcase
  end

endmodule
